// File: hdl/baro_altitude_drop_detector_assert.svh
// Assertion macros for the altitude drop detector datapath.
`ifndef BARO_ALTITUDE_DROP_DETECTOR_ASSERT_SVH
`define BARO_ALTITUDE_DROP_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BARO_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("baro: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BARO_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("baro: assertion failed");

`endif

// File: hdl/baro_pkg.sv
// Shared types and constants for the barometric altitude drop detector.
package baro_pkg;

    localparam int BARO_WINDOW_DEPTH = 10;

    localparam logic [16:0] PREF_RESET     = 17'd101325;
    localparam logic [13:0] THR_RESET      = 14'd20;
    localparam logic [31:0] EXPO_Q30       = 32'd204333069;
    localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
    localparam logic [31:0] ALT_SCALE_CM   = 32'd4433000;
    localparam logic [1:0]  CFG_REF_PRESS  = 2'd0;
    localparam logic [1:0]  CFG_DROP_THR   = 2'd1;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_LOG_INIT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SQ_STEP,
        OP_LOG_SAVE,
        OP_DIFF,
        OP_EXPO,
        OP_T,
        OP_DIV_INIT,
        OP_TERM,
        OP_POWER,
        OP_ALT,
        OP_ALT_SPECIAL,
        OP_RING,
        OP_CHECK
    } op_t;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MS_SQ,
        MS_EXPO,
        MS_LN2,
        MS_TERM,
        MS_RECIP,
        MS_ALT
    } mul_sel_t;

    typedef struct packed {
        op_t      op;
        mul_sel_t msel;
        logic     log_sel;   // 0: sample, 1: reference pressure
    } dp_cmd_t;

    typedef struct packed {
        logic p_zero;
        logic pref_zero;
        logic k_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/baro_ctrl.sv
// Sequencer for the altitude computation, window update and drop check.
module baro_ctrl
    import baro_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_SQ_LO, S_SQ_HI, S_SQ_ST, S_LOG_SAVE, S_LOG_INIT2,
        S_DIFF, S_EX_LO, S_EX_HI, S_EXPO, S_LN_LO, S_LN_HI, S_T,
        S_TM_LO, S_TM_HI, S_DV_INIT, S_DV_LO, S_DV_HI, S_TERM, S_POW,
        S_AL_LO, S_AL_HI, S_ALT, S_RING, S_CHECK
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        second_reg, second_next;

    assign in_stall = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        second_next = second_reg;
        cmd.op      = OP_NONE;
        cmd.msel    = MS_SQ;
        cmd.log_sel = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.p_zero || status.pref_zero)
                begin
                    cmd.op     = OP_ALT_SPECIAL;
                    state_next = S_RING;
                end
                else
                begin
                    cmd.op      = OP_LOG_INIT;
                    cmd.log_sel = 1'b0;
                    second_next = 1'b0;
                    cnt_next    = 5'd29;
                    state_next  = S_SQ_LO;
                end
            end
            S_SQ_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = S_SQ_HI;
            end
            S_SQ_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = S_SQ_ST;
            end
            S_SQ_ST:
            begin
                cmd.op = OP_SQ_STEP;
                if (cnt_reg == 5'd0)
                    state_next = second_reg ? S_DIFF : S_LOG_SAVE;
                else
                begin
                    cnt_next   = cnt_reg - 5'd1;
                    state_next = S_SQ_LO;
                end
            end
            S_LOG_SAVE:
            begin
                cmd.op     = OP_LOG_SAVE;
                state_next = S_LOG_INIT2;
            end
            S_LOG_INIT2:
            begin
                cmd.op      = OP_LOG_INIT;
                cmd.log_sel = 1'b1;
                second_next = 1'b1;
                cnt_next    = 5'd29;
                state_next  = S_SQ_LO;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_EX_LO;
            end
            S_EX_LO:
            begin
                cmd.op     = OP_MUL_LO;
                cmd.msel   = MS_EXPO;
                state_next = S_EX_HI;
            end
            S_EX_HI:
            begin
                cmd.op     = OP_MUL_HI;
                cmd.msel   = MS_EXPO;
                state_next = S_EXPO;
            end
            S_EXPO:
            begin
                cmd.op     = OP_EXPO;
                state_next = S_LN_LO;
            end
            S_LN_LO:
            begin
                cmd.op     = OP_MUL_LO;
                cmd.msel   = MS_LN2;
                state_next = S_LN_HI;
            end
            S_LN_HI:
            begin
                cmd.op     = OP_MUL_HI;
                cmd.msel   = MS_LN2;
                state_next = S_T;
            end
            S_T:
            begin
                cmd.op     = OP_T;
                state_next = S_TM_LO;
            end
            S_TM_LO:
            begin
                cmd.op     = OP_MUL_LO;
                cmd.msel   = MS_TERM;
                state_next = S_TM_HI;
            end
            S_TM_HI:
            begin
                cmd.op     = OP_MUL_HI;
                cmd.msel   = MS_TERM;
                state_next = S_DV_INIT;
            end
            S_DV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DV_LO;
            end
            // divide by k as a product with the reciprocal of k
            S_DV_LO:
            begin
                cmd.op     = OP_MUL_LO;
                cmd.msel   = MS_RECIP;
                state_next = S_DV_HI;
            end
            S_DV_HI:
            begin
                cmd.op     = OP_MUL_HI;
                cmd.msel   = MS_RECIP;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.op     = OP_TERM;
                state_next = status.k_last ? S_POW : S_TM_LO;
            end
            S_POW:
            begin
                cmd.op     = OP_POWER;
                state_next = S_AL_LO;
            end
            S_AL_LO:
            begin
                cmd.op     = OP_MUL_LO;
                cmd.msel   = MS_ALT;
                state_next = S_AL_HI;
            end
            S_AL_HI:
            begin
                cmd.op     = OP_MUL_HI;
                cmd.msel   = MS_ALT;
                state_next = S_ALT;
            end
            S_ALT:
            begin
                cmd.op     = OP_ALT;
                state_next = S_RING;
            end
            S_RING:
            begin
                cmd.op     = OP_RING;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.op     = OP_CHECK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= 5'd0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: hdl/baro_ring.sv
// Window of recent altitudes with per-entry valid bits cleared at reset.
module baro_ring
    import baro_pkg::*;
#(
    parameter int DEPTH = BARO_WINDOW_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic signed [23:0] wr_data,
    output logic signed [23:0] oldest
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic signed [23:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [PW-1:0]      wp_reg, wp_next;
    logic signed [23:0] rd_reg;

    assign wp_next = (wp_reg == LAST) ? '0 : wp_reg + PW'(1);
    assign oldest  = rd_reg;

    // Storage write and registered read of the entry after the new one
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
            rd_reg      <= valid_reg[wp_next] ? mem[wp_next] : 24'sd0;
        end
    end

    // Pointer and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            wp_reg            <= wp_next;
            valid_reg[wp_reg] <= 1'b1;
        end
    end

endmodule

// File: hdl/baro_dp.sv
// Datapath: log2 by squaring, exponent, Taylor power, altitude, drop check.
`include "baro_altitude_drop_detector_assert.svh"
module baro_dp
    import baro_pkg::*;
#(
    parameter int WINDOW_DEPTH = BARO_WINDOW_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic [16:0]        pressure_pa,
    input  logic               check_request,
    input  logic               confirm,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        pressure_out,
    output logic signed [23:0] altitude_cm,
    output logic signed [23:0] drop_cm,
    output logic               trigger_pending,
    output logic               fall_pulse
);

    logic [16:0] p_reg, pref_reg;
    logic [13:0] thr_reg;
    logic        chk_reg, cnf_reg;
    logic [30:0] x_reg;
    logic [29:0] bits_reg;
    logic [4:0]  top_reg;
    logic [34:0] lp_reg;
    logic        neg_reg;
    logic [34:0] mag_reg;
    logic [2:0]  nidx_reg;
    logic [29:0] f_reg, t_reg;
    logic [30:0] term_reg, div_reg;
    logic [31:0] sum_reg;
    logic [3:0]  k_reg;
    logic [35:0] amag_reg;
    logic        dneg_reg;
    logic signed [23:0] alt_reg;
    logic [67:0] acc_reg;
    logic        pending_reg;
    logic        out_valid_reg;
    logic [16:0] pout_reg;
    logic signed [23:0] aout_reg, dout_reg;
    logic        pulse_reg;

    logic signed [23:0] oldest;

    // Multiplier: one 18 x 32 product per cycle, two halves per operation
    logic [35:0] mul_a;
    logic [31:0] mul_b;
    logic [17:0] mul_half;
    logic [49:0] mul_prod;
    logic [35:0] recip;

    // ceil(2^34 / k): exact floor division of a 30-bit value by k
    always_comb
    begin
        case (k_reg)
            4'd1:    recip = 36'd17179869184;
            4'd2:    recip = 36'd8589934592;
            4'd3:    recip = 36'd5726623062;
            4'd4:    recip = 36'd4294967296;
            4'd5:    recip = 36'd3435973837;
            4'd6:    recip = 36'd2863311531;
            4'd7:    recip = 36'd2454267027;
            4'd8:    recip = 36'd2147483648;
            4'd9:    recip = 36'd1908874354;
            4'd10:   recip = 36'd1717986919;
            4'd11:   recip = 36'd1561806290;
            4'd12:   recip = 36'd1431655766;
            4'd13:   recip = 36'd1321528399;
            4'd14:   recip = 36'd1227133514;
            4'd15:   recip = 36'd1145324613;
            default: recip = 36'd0;
        endcase
    end

    always_comb
    begin
        case (cmd.msel)
            MS_SQ:    begin mul_a = {5'd0, x_reg};    mul_b = {1'b0, x_reg};   end
            MS_EXPO:  begin mul_a = {1'b0, mag_reg};  mul_b = EXPO_Q30;        end
            MS_LN2:   begin mul_a = {6'd0, f_reg};    mul_b = LN2_Q32;         end
            MS_TERM:  begin mul_a = {5'd0, term_reg}; mul_b = {2'd0, t_reg};   end
            MS_RECIP: begin mul_a = recip;            mul_b = {1'b0, div_reg}; end
            MS_ALT:   begin mul_a = amag_reg;         mul_b = ALT_SCALE_CM;    end
            default:  begin mul_a = '0;               mul_b = '0;              end
        endcase
    end

    assign mul_half = (cmd.op == OP_MUL_HI) ? mul_a[35:18] : mul_a[17:0];
    assign mul_prod = mul_half * mul_b;

    // Normalization of the log operand
    logic [16:0] log_v;
    logic [4:0]  log_top;
    logic [30:0] log_x;

    always_comb
    begin
        log_v   = cmd.log_sel ? pref_reg : p_reg;
        log_top = 5'd0;
        for (int i = 1; i < 17; i++)
        begin
            if (log_v[i])
                log_top = 5'(i);
        end
        log_x = {14'd0, log_v} << (5'd30 - log_top);
    end

    // Step results
    logic [31:0] sq;
    logic signed [35:0] diff;
    logic [32:0] m2;
    logic signed [34:0] w_val, u_val;
    logic [29:0] quot;
    logic [35:0] power;
    logic signed [36:0] d_val;
    logic [37:0] prod_r;
    logic [67:0] rounded;
    logic signed [24:0] drop;
    logic        drop_hit, pend_after;
    logic signed [23:0] drop_sat;

    always_comb
    begin
        sq     = acc_reg[61:30];
        diff   = $signed({1'b0, lp_reg}) - $signed({1'b0, top_reg, bits_reg});
        m2     = acc_reg[62:30];
        w_val  = neg_reg ? -$signed({2'b0, m2}) : $signed({2'b0, m2});
        u_val  = w_val + $signed(35'd4 << 30);
        quot   = acc_reg[63:34];
        if (nidx_reg[2])
            power = {4'd0, sum_reg} << nidx_reg[1:0];
        else
            power = {4'd0, sum_reg} >> (3'd4 - nidx_reg);
        d_val   = $signed(37'd1 << 30) - $signed({1'b0, power});
        rounded = acc_reg + (68'd1 << 29);
        prod_r  = rounded[67:30];
        drop     = $signed({oldest[23], oldest}) - $signed({alt_reg[23], alt_reg});
        drop_hit = chk_reg && (drop > $signed({11'd0, thr_reg}));
        pend_after = pending_reg || drop_hit;
        if (drop > 25'sd8388607)
            drop_sat = 24'sh7FFFFF;
        else if (drop < -25'sd8388608)
            drop_sat = -24'sd8388608;
        else
            drop_sat = drop[23:0];
    end

    baro_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd.op == OP_RING),
        .wr_data (alt_reg),
        .oldest  (oldest)
    );

    // Working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                p_reg   <= pressure_pa;
                chk_reg <= check_request;
                cnf_reg <= confirm;
            end
            OP_LOG_INIT:
            begin
                x_reg    <= log_x;
                top_reg  <= log_top;
                bits_reg <= '0;
            end
            OP_MUL_LO: acc_reg <= {18'd0, mul_prod};
            OP_MUL_HI: acc_reg <= acc_reg + ({18'd0, mul_prod} << 18);
            OP_SQ_STEP:
            begin
                bits_reg <= {bits_reg[28:0], sq[31]};
                x_reg    <= sq[31] ? sq[31:1] : sq[30:0];
            end
            OP_LOG_SAVE: lp_reg <= {top_reg, bits_reg};
            OP_DIFF:
            begin
                neg_reg <= diff[35];
                mag_reg <= diff[35] ? 35'(-diff) : diff[34:0];
            end
            OP_EXPO:
            begin
                nidx_reg <= u_val[32:30];
                f_reg    <= u_val[29:0];
            end
            OP_T:
            begin
                t_reg    <= acc_reg[61:32];
                term_reg <= 31'd1 << 30;
                sum_reg  <= 32'd1 << 30;
                k_reg    <= 4'd1;
            end
            OP_DIV_INIT:
            begin
                div_reg <= acc_reg[60:30];
            end
            OP_TERM:
            begin
                term_reg <= {1'b0, quot};
                sum_reg  <= sum_reg + {2'b0, quot};
                k_reg    <= k_reg + 4'd1;
            end
            OP_POWER:
            begin
                dneg_reg <= d_val[36];
                amag_reg <= d_val[36] ? 36'(-d_val) : d_val[35:0];
            end
            OP_ALT:
            begin
                if (!dneg_reg)
                    alt_reg <= (prod_r > 38'd8388607) ? 24'sh7FFFFF : prod_r[23:0];
                else
                    alt_reg <= (prod_r > 38'd8388608) ? -24'sd8388608 : 24'(-prod_r);
            end
            OP_ALT_SPECIAL:
            begin
                alt_reg <= (p_reg == 17'd0) ? 24'(ALT_SCALE_CM) : -24'sd8388608;
            end
            OP_CHECK:
            begin
                pout_reg  <= p_reg;
                aout_reg  <= alt_reg;
                dout_reg  <= chk_reg ? drop_sat : 24'sd0;
                pulse_reg <= pend_after && cnf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration, pending flag and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pref_reg      <= PREF_RESET;
            thr_reg       <= THR_RESET;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_REF_PRESS)
                pref_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_DROP_THR)
                thr_reg <= cfg_data[13:0];
            if (cmd.op == OP_CHECK)
            begin
                pending_reg   <= pend_after && !cnf_reg;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.p_zero    = (p_reg == 17'd0);
    assign status.pref_zero = (pref_reg == 17'd0);
    assign status.k_last    = (k_reg == 4'd15);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid       = out_valid_reg;
    assign pressure_out    = pout_reg;
    assign altitude_cm     = aout_reg;
    assign drop_cm         = dout_reg;
    assign trigger_pending = pending_reg;
    assign fall_pulse      = pulse_reg;

    // A held result is never overwritten
    `BARO_ASSERT_IMP(a_no_overwrite, cmd.op == OP_CHECK, !out_valid_reg || !out_stall)
    // A fired pulse leaves nothing pending
    `BARO_ASSERT_IMP(a_pulse_clears, out_valid_reg && pulse_reg, !pending_reg)
    // Term index stays within the reciprocal table
    `BARO_ASSERT_IMP(a_k_range, cmd.op == OP_TERM, k_reg != 4'd0)

endmodule

// File: hdl/baro_altitude_drop_detector.sv
// Top level of the barometric altitude drop detector.
//
// Input channel (in_valid / in_stall): one transaction per pressure sample with
// pressure_pa, check_request and confirm. Output channel (out_valid /
// out_stall): one result transaction per sample, in order.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0
// is the reference pressure, index 1 the drop threshold; other indexes are
// ignored. cfg_ready is always high; write only while the block is idle.
//
// out_valid rises once a sample has gone through two 30-step log2 squarings
// on the shared 18x32 multiplier, 15 Taylor terms (term product, then divide
// by k as a product with its reciprocal) and the setup, exponent and altitude
// steps. A new sample is not taken while one is still being worked on. Zero
// pressure or reference skip the math. A new sample is taken once the
// previous one has been moved to the output register, even while that
// result waits.
//
// Reset (rst_n, asynchronous, active low) clears the altitude window via
// valid bits at once, the pointer and the pending flag, and restores the
// register defaults. While the receiver stalls, the result holds steady and
// the next sample stops just before loading the output register.
module baro_altitude_drop_detector
    import baro_pkg::*;
#(
    parameter int WINDOW_DEPTH = BARO_WINDOW_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [16:0]        pressure_pa,
    input  logic               check_request,
    input  logic               confirm,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        pressure_out,
    output logic signed [23:0] altitude_cm,
    output logic signed [23:0] drop_cm,
    output logic               trigger_pending,
    output logic               fall_pulse,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    baro_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    baro_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pressure_pa     (pressure_pa),
        .check_request   (check_request),
        .confirm         (confirm),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pressure_out    (pressure_out),
        .altitude_cm     (altitude_cm),
        .drop_cm         (drop_cm),
        .trigger_pending (trigger_pending),
        .fall_pulse      (fall_pulse)
    );

endmodule

// File: bench/baro_altitude_drop_detector_tb.sv
// Self-checking testbench for the barometric altitude drop detector.
module baro_altitude_drop_detector_tb
    import baro_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q30_ONE = 64'd1 << 30;
    localparam longint ALT_MAX = 8388607;
    localparam longint ALT_MIN = -8388608;

    // Register indexes outside the register list
    localparam logic [1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [1:0] CFG_UNUSED_HI = 2'd3;

    // One expected result transaction
    typedef struct {
        logic [16:0]        pressure;
        logic signed [23:0] altitude;
        logic signed [23:0] drop;
        logic               pending;
        logic               pulse;
    } alt_result_t;

    // Altitude predictor plus queue of expected results
    class altitude_scoreboard;
        alt_result_t        expected_q[$];
        int                 errors;
        longint             window[BARO_WINDOW_DEPTH];
        int                 wr_ptr;
        bit                 armed;
        bit [16:0]          p_ref;
        bit [13:0]          threshold;

        function void clear();
            foreach (window[i]) window[i] = 0;
            wr_ptr    = 0;
            armed     = 0;
            p_ref     = PREF_RESET;
            threshold = THR_RESET;
            errors    = 0;
            expected_q.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [16:0] data);
            if (idx == CFG_REF_PRESS)
                p_ref = data;
            else if (idx == CFG_DROP_THR)
                threshold = data[13:0];
        endfunction

        function longint clip24(longint v);
            if (v > ALT_MAX) return ALT_MAX;
            if (v < ALT_MIN) return ALT_MIN;
            return v;
        endfunction

        // log2 in Q30 by repeated squaring
        function longint log2_fixed(bit [16:0] v);
            int       top;
            bit [63:0] x;
            bit [63:0] frac;
            top  = 0;
            frac = 0;
            while (top < 16 && (v >> (top + 1)) != 0) top++;
            x = 64'(v) << (30 - top);
            for (int i = 0; i < 30; i++) begin
                x = (x * x) >> 30;
                frac = frac << 1;
                if (x >= 2 * Q30_ONE) begin
                    frac = frac | 1;
                    x = x >> 1;
                end
            end
            return longint'((64'(top) << 30) | frac);
        endfunction

        // 2^w in Q30 via Taylor series of e^(f ln2)
        function bit [63:0] exp2_fixed(longint w);
            bit [63:0] u;
            int        n;
            bit [63:0] f;
            bit [63:0] t;
            bit [63:0] term;
            bit [63:0] acc;
            u    = w + 4 * Q30_ONE;
            n    = int'(u >> 30) - 4;
            f    = u & (Q30_ONE - 1);
            t    = (f * 64'hB17217F8) >> 32;
            term = Q30_ONE;
            acc  = Q30_ONE;
            for (int k = 1; k <= 15; k++) begin
                term = ((term * t) >> 30) / k;
                acc  = acc + term;
            end
            if (n >= 0) return acc << n;
            return acc >> (-n);
        endfunction

        function longint altitude_of(bit [16:0] p);
            longint    diff;
            longint    w;
            longint    d;
            bit [63:0] mag;
            bit [63:0] prod;
            if (p == 0) return 4433000;
            if (p_ref == 0) return ALT_MIN;
            diff = log2_fixed(p) - log2_fixed(p_ref);
            mag  = diff < 0 ? -diff : diff;
            mag  = (mag * 64'd204333069) >> 30;
            w    = diff < 0 ? -longint'(mag) : longint'(mag);
            d    = Q30_ONE - longint'(exp2_fixed(w));
            mag  = d < 0 ? -d : d;
            prod = (mag * 64'd4433000 + (Q30_ONE >> 1)) >> 30;
            return clip24(d < 0 ? -longint'(prod) : longint'(prod));
        endfunction

        // Accepted input: update predictor state and queue the result
        function void note_input(bit [16:0] p, bit chk, bit conf);
            alt_result_t r;
            longint      alt;
            longint      drop;
            alt = altitude_of(p);
            window[wr_ptr] = alt;
            wr_ptr = (wr_ptr + 1) % BARO_WINDOW_DEPTH;
            r.drop  = 0;
            r.pulse = 0;
            if (chk) begin
                drop = window[wr_ptr] - alt;
                if (drop > longint'(threshold)) armed = 1;
                r.drop = 24'(clip24(drop));
            end
            if (armed && conf) begin
                armed   = 0;
                r.pulse = 1;
            end
            r.pressure = p;
            r.altitude = 24'(alt);
            r.pending  = armed;
            expected_q.push_back(r);
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(alt_result_t a);
            alt_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got pressure %0d",
                         $time, a.pressure);
                return;
            end
            e = expected_q.pop_front();
            cmp("pressure_out", e.pressure, a.pressure);
            cmp("altitude_cm", e.altitude, a.altitude);
            cmp("drop_cm", e.drop, a.drop);
            cmp("trigger_pending", e.pending, a.pending);
            cmp("fall_pulse", e.pulse, a.pulse);
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [16:0]        pressure_pa = 0;
    logic               check_request = 0;
    logic               confirm = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [16:0]        pressure_out;
    logic signed [23:0] altitude_cm;
    logic signed [23:0] drop_cm;
    logic               trigger_pending;
    logic               fall_pulse;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 0;
    logic [16:0]        cfg_data = 0;

    altitude_scoreboard sb;
    bit                 no_idle;

    baro_altitude_drop_detector dut (.*);

    always #1 clk = ~clk;

    // Run limit
    initial
    begin
        #20ms;
        $display("baro_altitude_drop_detector_tb: FAIL");
        $finish;
    end

    // Register write transaction
    task automatic write_cfg(logic [1:0] idx, logic [16:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // One sample transaction, with a random lead-in gap
    task automatic send_sample(int p, bit chk, bit conf);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1;
        pressure_pa   <= p[16:0];
        check_request <= chk;
        confirm       <= conf;
        do @(posedge clk); while (in_stall);
        sb.note_input(p[16:0], chk, conf);
    endtask

    // Stop sending and wait for every expected result
    task automatic drain();
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int clamp_p(int p);
        if (p < 1) return 1;
        if (p > 131071) return 131071;
        return p;
    endfunction

    // Ramps of samples with random content, mixed with noise
    task automatic random_samples(int count);
        int sent;
        int len;
        int base;
        int step;
        sent = 0;
        while (sent < count)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            len = $urandom_range(4, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                base = $urandom_range(60000, 120000);
                step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6000)
                                                   : $urandom_range(0, 400);
                if ($urandom_range(0, 1)) step = -step;
                for (int i = 0; i < len; i++)
                    send_sample(clamp_p(base + i * step + $urandom_range(0, 20)),
                                1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0);
            end
            else
            begin
                for (int i = 0; i < len; i++)
                    send_sample($urandom_range(0, 131071), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end
            sent += len;
        end
        no_idle = 0;
    endtask

    // Result side: random stall, then accept and check
    initial
    begin
        int          n;
        alt_result_t a;
        @(posedge rst_n);
        forever
        begin
            n = no_idle ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
            do @(posedge clk); while (!out_valid);
            a.pressure = pressure_out;
            a.altitude = altitude_cm;
            a.drop     = drop_cm;
            a.pending  = trigger_pending;
            a.pulse    = fall_pulse;
            sb.check_result(a);
        end
    end

    // Stimulus
    initial
    begin
        sb = new();
        sb.clear();
        no_idle = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, early checks, confirm handling, zero pressure
        send_sample(101325, 1, 0);
        send_sample(0, 1, 1);
        send_sample(1, 0, 1);
        send_sample(131071, 1, 0);
        send_sample(101325, 1, 1);
        for (int i = 0; i < 6; i++) send_sample(90000 + i * 2000, 1, 0);
        send_sample(103000, 1, 1);
        send_sample(99000, 1, 1);
        send_sample(80000, 0, 0);
        send_sample(104000, 1, 0);
        send_sample(104000, 0, 1);
        drain();

        // Low reference, zero threshold
        write_cfg(CFG_REF_PRESS, 17'd80000);
        write_cfg(CFG_DROP_THR, 17'd0);
        write_cfg(CFG_UNUSED_HI, 17'h1FFFF);
        random_samples(180);
        drain();
        random_samples(40);
        drain();

        // High reference, threshold of 10000
        write_cfg(CFG_REF_PRESS, 17'd110000);
        write_cfg(CFG_DROP_THR, 17'd10000);
        random_samples(180);
        drain();

        // Zero reference, all-ones threshold
        write_cfg(CFG_REF_PRESS, 17'd0);
        write_cfg(CFG_DROP_THR, 17'h03FFF);
        write_cfg(CFG_UNUSED_LO, 17'd5);
        random_samples(60);
        drain();

        // All-ones reference, threshold of 150
        write_cfg(CFG_REF_PRESS, 17'h1FFFF);
        write_cfg(CFG_DROP_THR, 17'd150);
        random_samples(150);
        drain();

        // Typical sea-level setting
        write_cfg(CFG_REF_PRESS, 17'd101325);
        write_cfg(CFG_DROP_THR, 17'd20);
        random_samples(320);
        drain();

        if (sb.errors == 0)
            $display("baro_altitude_drop_detector_tb: PASS");
        else
            $display("baro_altitude_drop_detector_tb: FAIL");
        $finish;
    end
endmodule
